FILE: design/hpt_pkg.sv
`default_nettype none
package hpt_pkg;
  localparam int unsigned TableEntries = 1024;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned LinkW = IdxW + 1;
  localparam logic [LinkW-1:0] NullLink = LinkW'(TableEntries);
  localparam int unsigned SlotW = 32 + 20 + 20 + 2 + LinkW;

  typedef enum logic [1:0] {
    OpLookup = 2'd0,
    OpInsert = 2'd1,
    OpRemove = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    StDone = 2'd0,
    StNotFound = 2'd1,
    StFull = 2'd2
  } status_e;

  typedef struct packed {
    logic [31:0] proc_id;
    logic [19:0] page;
    logic [19:0] frame;
    logic [1:0] flags;
    logic [LinkW-1:0] link;
  } slot_t;

  typedef enum logic [3:0] {
    SClear, SIdle, SLkRd, SLkChk, SInsHome, SInsTail, SInsWalk, SInsProbe, SInsLink,
    SInsFix, SRmRd, SRmChk, SRmNx, SRmClr, SOut
  } state_e;
endpackage
`default_nettype wire

FILE: design/hpt_ram.sv
`default_nettype none
module hpt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: design/hashed_page_table_engine_core.sv
// work per transfer: lookup checks chain slots; insert writes a free home slot, else
//   reads the chain and probes slots; remove passes over every slot and pulls in
//   successors
// flow: one item at a time; in_ready_o rises in the cycle after the result is taken
// reset: rst_ni clears control at once, then a clearing pass writes every slot, one per
//   cycle, before the first transfer
`default_nettype none
module hashed_page_table_engine_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [31:0] proc_id_i,
  input  wire logic [19:0] page_i,
  input  wire logic [19:0] frame_i,
  input  wire logic        writable_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             hit_o,
  output logic [19:0]      frame_out_o,
  output logic             writable_out_o,
  output logic [1:0]       status_o
);
  import hpt_pkg::*;

  state_e state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d, tail_q, tail_d, scan_q, scan_d;
  logic [LinkW-1:0] cnt_q, cnt_d;
  logic [31:0] pid_q, pid_d;
  logic [19:0] page_q, page_d, frame_q, frame_d;
  logic wr_q, wr_d;
  slot_t cur_q, cur_d;
  logic hit_q, hit_d;
  logic [19:0] fo_q, fo_d;
  logic wo_q, wo_d;
  logic [1:0] st_q, st_d;

  logic we;
  logic [IdxW-1:0] waddr, raddr;
  slot_t wdata, rdata;

  hpt_ram #(.Width(SlotW), .Depth(TableEntries)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  slot_t empty_slot, new_slot;
  logic [IdxW-1:0] home;
  logic rvalid, link_ok, last_idx;
  logic [IdxW-1:0] link_idx;
  always_comb begin
    empty_slot = '0;
    empty_slot.link = NullLink;
    new_slot.proc_id = pid_q;
    new_slot.page = page_q;
    new_slot.frame = frame_q;
    new_slot.flags = {wr_q, 1'b1};
    new_slot.link = NullLink;
    home = IdxW'(proc_id_i ^ 32'(page_i));
    rvalid = rdata.flags[0];
    link_ok = (rdata.link < LinkW'(TableEntries));
    link_idx = rdata.link[IdxW-1:0];
    last_idx = (idx_q == IdxW'(TableEntries - 1));
  end

  always_comb begin
    state_d = state_q;
    idx_d = idx_q; tail_d = tail_q; scan_d = scan_q; cnt_d = cnt_q;
    pid_d = pid_q; page_d = page_q; frame_d = frame_q; wr_d = wr_q;
    cur_d = cur_q;
    hit_d = hit_q; fo_d = fo_q; wo_d = wo_q; st_d = st_q;
    we = 1'b0; waddr = idx_q; wdata = empty_slot; raddr = idx_q;
    case (state_q)
      SClear: begin
        we = 1'b1;
        idx_d = idx_q + 1'b1;
        if (last_idx) state_d = SIdle;
      end
      SIdle: begin
        if (in_valid_i) begin
          pid_d = proc_id_i; page_d = page_i; frame_d = frame_i; wr_d = writable_i;
          idx_d = home; cnt_d = '0; scan_d = '0;
          hit_d = 1'b0; fo_d = '0; wo_d = 1'b0; st_d = StDone;
          case (op_i)
            OpLookup: state_d = SLkRd;
            OpInsert: state_d = SInsHome;
            OpRemove: begin idx_d = '0; state_d = SRmRd; end
            default: begin st_d = StNotFound; state_d = SOut; end
          endcase
        end
      end
      SLkRd: state_d = SLkChk;
      SLkChk: begin
        if (!rvalid || cnt_q == LinkW'(TableEntries)) begin
          st_d = StNotFound; state_d = SOut;
        end else if (rdata.proc_id == pid_q && rdata.page == page_q) begin
          hit_d = 1'b1; fo_d = rdata.frame; wo_d = rdata.flags[1];
          state_d = SOut;
        end else if (!link_ok) begin
          st_d = StNotFound; state_d = SOut;
        end else begin
          idx_d = link_idx; cnt_d = cnt_q + 1'b1; raddr = link_idx;
        end
      end
      SInsHome: state_d = SInsTail;
      SInsTail: begin
        if (!rvalid) begin
          we = 1'b1; wdata = new_slot;
          fo_d = frame_q; wo_d = wr_q; state_d = SOut;
        end else begin
          tail_d = idx_q; cur_d = rdata;
          if (link_ok) begin
            idx_d = link_idx; raddr = link_idx; state_d = SInsWalk;
          end else begin
            idx_d = idx_q + IdxW'(TableEntries / 2); state_d = SInsProbe;
          end
        end
      end
      SInsWalk: begin
        if (rvalid && cnt_q != LinkW'(TableEntries)) begin
          tail_d = idx_q; cur_d = rdata; cnt_d = cnt_q + 1'b1;
          if (link_ok) begin
            idx_d = link_idx; raddr = link_idx;
          end else begin
            idx_d = idx_q + IdxW'(TableEntries / 2); state_d = SInsProbe;
          end
        end else begin
          idx_d = tail_q + IdxW'(TableEntries / 2); state_d = SInsProbe;
        end
      end
      SInsProbe: state_d = SInsLink;
      SInsLink: begin
        if (!rvalid) begin
          we = 1'b1; wdata = new_slot;
          cur_d.link = {1'b0, idx_q};
          fo_d = frame_q; wo_d = wr_q;
          state_d = SInsFix;
        end else if (scan_q == IdxW'(TableEntries - 1)) begin
          st_d = StFull; state_d = SOut;
        end else begin
          scan_d = scan_q + 1'b1; idx_d = idx_q + 1'b1; raddr = idx_q + 1'b1;
        end
      end
      SInsFix: begin
        we = 1'b1; waddr = tail_q; wdata = cur_q; state_d = SOut;
      end
      SRmRd: state_d = SRmChk;
      SRmChk: begin
        if (!rvalid || rdata.proc_id != pid_q || cnt_q == LinkW'(TableEntries)) begin
          cnt_d = '0;
          if (last_idx) state_d = SOut;
          else begin idx_d = idx_q + 1'b1; state_d = SRmRd; end
        end else if (link_ok && link_idx != idx_q) begin
          raddr = link_idx; tail_d = link_idx; state_d = SRmNx;
        end else begin
          we = 1'b1; cnt_d = '0;
          if (last_idx) state_d = SOut;
          else begin idx_d = idx_q + 1'b1; state_d = SRmRd; end
        end
      end
      SRmNx: begin
        we = 1'b1;
        if (rvalid) begin
          wdata = rdata; state_d = SRmClr;
        end else begin
          cnt_d = '0;
          if (last_idx) state_d = SOut;
          else begin idx_d = idx_q + 1'b1; state_d = SRmRd; end
        end
      end
      SRmClr: begin
        we = 1'b1; waddr = tail_q;
        cnt_d = cnt_q + 1'b1; state_d = SRmRd;
      end
      SOut: begin
        if (out_ready_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == SIdle);
    out_valid_o = (state_q == SOut);
    hit_o = hit_q;
    frame_out_o = fo_q;
    writable_out_o = wo_q;
    status_o = st_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      idx_q <= '0; tail_q <= '0; scan_q <= '0; cnt_q <= '0;
      pid_q <= '0; page_q <= '0; frame_q <= '0; wr_q <= 1'b0;
      cur_q <= '0;
      hit_q <= 1'b0; fo_q <= '0; wo_q <= 1'b0; st_q <= StDone;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d; tail_q <= tail_d; scan_q <= scan_d; cnt_q <= cnt_d;
      pid_q <= pid_d; page_q <= page_d; frame_q <= frame_d; wr_q <= wr_d;
      cur_q <= cur_d;
      hit_q <= hit_d; fo_q <= fo_d; wo_q <= wo_d; st_q <= st_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(in_ready_o && out_valid_o))
    else $error("ready while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> ($stable(status_o) && $stable(frame_out_o)))
    else $error("result changed while waiting");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == StDone || status_o == StNotFound || status_o == StFull))
    else $error("bad status");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hit_o) |-> (status_o == StDone)) else $error("hit without done");
endmodule
`default_nettype wire

FILE: verif/page_table_checker.sv
`timescale 1ns / 100ps
module page_table_checker
  import hpt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  op_i,
  input  logic [31:0] proc_id_i,
  input  logic [19:0] page_i,
  input  logic [19:0] frame_i,
  input  logic        writable_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        hit_i,
  input  logic [19:0] frame_out_i,
  input  logic        writable_out_i,
  input  logic [1:0]  status_i,
  output int          mismatches_o,
  output int          pending_o
);
  typedef struct packed {
    logic        hit;
    logic [19:0] frame;
    logic        writable;
    logic [1:0]  status;
  } mapping_result_t;

  localparam int unsigned Half = TableEntries / 2;

  logic [31:0]      pt_proc  [TableEntries];
  logic [19:0]      pt_page  [TableEntries];
  logic [19:0]      pt_frame [TableEntries];
  logic [1:0]       pt_flags [TableEntries];
  logic [LinkW-1:0] pt_link  [TableEntries];

  mapping_result_t pending_results[$];

  assign pending_o = pending_results.size();

  function automatic bit slot_live(int unsigned i);
    return i < TableEntries && pt_flags[i][0];
  endfunction

  function automatic void wipe_slot(int unsigned i);
    pt_proc[i] = '0;
    pt_page[i] = '0;
    pt_frame[i] = '0;
    pt_flags[i] = '0;
    pt_link[i] = NullLink;
  endfunction

  function automatic void fill_slot(int unsigned i, logic [31:0] pid, logic [19:0] pg,
                                    logic [19:0] fr, logic wr);
    pt_proc[i] = pid;
    pt_page[i] = pg;
    pt_frame[i] = fr;
    pt_flags[i] = {wr, 1'b1};
    pt_link[i] = NullLink;
  endfunction

  function automatic mapping_result_t lookup_mapping(logic [31:0] pid, logic [19:0] pg);
    int unsigned i;
    mapping_result_t r;
    i = (pid ^ 32'(pg)) % TableEntries;
    r = '{1'b0, 20'd0, 1'b0, StNotFound};
    for (int unsigned n = 0; n < TableEntries && slot_live(i); n++) begin
      if (pt_proc[i] == pid && pt_page[i] == pg) begin
        r = '{1'b1, pt_frame[i], pt_flags[i][1], StDone};
        return r;
      end
      i = pt_link[i];
    end
    return r;
  endfunction

  function automatic mapping_result_t insert_mapping(logic [31:0] pid, logic [19:0] pg,
                                                     logic [19:0] fr, logic wr);
    int unsigned i, p;
    i = (pid ^ 32'(pg)) % TableEntries;
    if (!slot_live(i)) begin
      fill_slot(i, pid, pg, fr, wr);
      return '{1'b0, fr, wr, StDone};
    end
    for (int unsigned n = 0; n < TableEntries && slot_live(pt_link[i]); n++)
      i = pt_link[i];
    p = (i + Half) % TableEntries;
    for (int unsigned n = 0; n < TableEntries; n++) begin
      if (!slot_live(p)) begin
        pt_link[i] = LinkW'(p);
        fill_slot(p, pid, pg, fr, wr);
        return '{1'b0, fr, wr, StDone};
      end
      p = (p + 1) % TableEntries;
    end
    return '{1'b0, 20'd0, 1'b0, StFull};
  endfunction

  function automatic mapping_result_t purge_process(logic [31:0] pid);
    int unsigned nx;
    for (int unsigned i = 0; i < TableEntries; i++) begin
      for (int unsigned n = 0; n < TableEntries; n++) begin
        if (!slot_live(i) || pt_proc[i] != pid) break;
        nx = pt_link[i];
        if (nx != i && slot_live(nx)) begin
          pt_proc[i] = pt_proc[nx];
          pt_page[i] = pt_page[nx];
          pt_frame[i] = pt_frame[nx];
          pt_flags[i] = pt_flags[nx];
          pt_link[i] = pt_link[nx];
          wipe_slot(nx);
        end else begin
          wipe_slot(i);
          break;
        end
      end
    end
    return '{1'b0, 20'd0, 1'b0, StDone};
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatches_o++;
  endtask

  initial begin
    mismatches_o = 0;
    for (int unsigned i = 0; i < TableEntries; i++) wipe_slot(i);
  end

  always @(posedge clk_i) begin
    mapping_result_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          report("unexpected transfer", 32'(status_i), 32'hx);
        end else begin
          want = pending_results.pop_front();
          if (hit_i !== want.hit) report("hit", 32'(hit_i), 32'(want.hit));
          if (frame_out_i !== want.frame) report("frame", 32'(frame_out_i), 32'(want.frame));
          if (writable_out_i !== want.writable)
            report("writable", 32'(writable_out_i), 32'(want.writable));
          if (status_i !== want.status) report("status", 32'(status_i), 32'(want.status));
        end
      end
      if (in_valid_i && in_ready_i) begin
        case (op_i)
          OpLookup: want = lookup_mapping(proc_id_i, page_i);
          OpInsert: want = insert_mapping(proc_id_i, page_i, frame_i, writable_i);
          OpRemove: want = purge_process(proc_id_i);
          default:  want = '{1'b0, 20'd0, 1'b0, StNotFound};
        endcase
        pending_results.push_back(want);
      end
    end
  end

  final begin
    if (pending_results.size() != 0)
      $display("mismatch: %0d results never arrived", pending_results.size());
  end
endmodule

FILE: verif/tb_hashed_page_table_engine_core.sv
`timescale 1ns / 100ps
module tb_hashed_page_table_engine_core;
  import hpt_pkg::*;

  localparam logic [1:0] OpBad = 2'd3;
  localparam int StallLimit = 40000;
  localparam int RandomItems = 500;
  localparam logic [31:0] FillPid = 32'h5a5a_1234;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  op_i;
  logic [31:0] proc_id_i;
  logic [19:0] page_i;
  logic [19:0] frame_i;
  logic        writable_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        hit_o;
  logic [19:0] frame_out_o;
  logic        writable_out_o;
  logic [1:0]  status_o;

  int mismatches;
  int pending;
  int idle_cycles;
  bit calm;

  logic [31:0] pid_pool[4];
  logic [31:0] known_pid[$];
  logic [19:0] known_page[$];

  hashed_page_table_engine_core u_top (.*);

  page_table_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .op_i, .proc_id_i, .page_i,
    .frame_i, .writable_i, .out_valid_i(out_valid_o), .out_ready_i, .hit_i(hit_o),
    .frame_out_i(frame_out_o), .writable_out_i(writable_out_o), .status_i(status_o),
    .mismatches_o(mismatches), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= 18);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(logic [1:0] op, logic [31:0] pid, logic [19:0] pg, logic [19:0] fr,
                      logic wr);
    while (!calm && $urandom_range(0, 99) < 18) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    proc_id_i <= pid;
    page_i <= pg;
    frame_i <= fr;
    writable_i <= wr;
    do @(posedge clk_i); while (!in_ready_o);
    if (op == OpInsert) begin
      known_pid.push_back(pid);
      known_page.push_back(pg);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic random_item();
    int unsigned sel, k;
    logic [31:0] pid;
    logic [19:0] pg;
    pid = ($urandom_range(0, 99) < 80) ? pid_pool[$urandom_range(0, 3)] : $urandom;
    if ($urandom_range(0, 99) < 70)
      pg = {10'($urandom), pid[9:0] ^ 10'($urandom_range(0, 7))};
    else
      pg = 20'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      send(OpInsert, pid, pg, 20'($urandom), 1'($urandom));
    end else if (sel < 93) begin
      if (known_pid.size() != 0 && $urandom_range(0, 99) < 60) begin
        k = $urandom_range(0, known_pid.size() - 1);
        send(OpLookup, known_pid[k], known_page[k], 20'($urandom), 1'($urandom));
      end else begin
        send(OpLookup, pid, pg, 20'($urandom), 1'($urandom));
      end
    end else if (sel < 97) begin
      send(OpRemove, pid, pg, 20'($urandom), 1'($urandom));
    end else begin
      send(OpBad, pid, pg, 20'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    op_i = OpLookup;
    proc_id_i = '0;
    page_i = '0;
    frame_i = '0;
    writable_i = 1'b0;
    out_ready_i = 1'b0;
    idle_cycles = 0;
    calm = 1'b0;
    foreach (pid_pool[i]) pid_pool[i] = $urandom;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // extremes, duplicates, chains and pulled-in successors
    send(OpInsert, 32'h0, 20'h0, 20'h0, 1'b0);
    send(OpInsert, 32'hffff_ffff, 20'hfffff, 20'hfffff, 1'b1);
    send(OpLookup, 32'h0, 20'h0, 20'h0, 1'b0);
    send(OpLookup, 32'hffff_ffff, 20'hfffff, 20'h0, 1'b0);
    send(OpLookup, 32'h1234_5678, 20'h0_0001, 20'h0, 1'b0);
    send(OpInsert, 32'h0, 20'h0, 20'h5_5555, 1'b1);
    send(OpInsert, 32'h0, 20'h400, 20'ha_aaaa, 1'b0);
    send(OpInsert, 32'h7, 20'h407, 20'h1_2345, 1'b1);
    send(OpLookup, 32'h0, 20'h400, 20'h0, 1'b0);
    send(OpLookup, 32'h7, 20'h407, 20'h0, 1'b0);
    send(OpBad, 32'hffff_ffff, 20'hfffff, 20'hfffff, 1'b1);
    send(OpRemove, 32'h0, 20'h0, 20'h0, 1'b0);
    send(OpLookup, 32'h0, 20'h0, 20'h0, 1'b0);
    send(OpLookup, 32'h7, 20'h407, 20'h0, 1'b0);
    send(OpInsert, 32'h8, 20'h8, 20'h3_0303, 1'b1);
    send(OpLookup, 32'h8, 20'h8, 20'h0, 1'b0);
    send(OpRemove, 32'hffff_ffff, 20'h0, 20'h0, 1'b0);
    send(OpLookup, 32'hffff_ffff, 20'hfffff, 20'h0, 1'b0);
    drain();

    // fill every slot, then overflow
    calm = 1'b1;
    for (int i = 0; i < TableEntries + 2; i++)
      send(OpInsert, FillPid, 20'(i), 20'($urandom), 1'($urandom));
    calm = 1'b0;
    send(OpInsert, 32'h8, 20'h9, 20'hfffff, 1'b1);
    send(OpLookup, FillPid, 20'(TableEntries - 1), 20'h0, 1'b0);
    send(OpRemove, FillPid, 20'h0, 20'h0, 1'b0);
    send(OpLookup, FillPid, 20'h3, 20'h0, 1'b0);
    known_pid.delete();
    known_page.delete();

    for (int n = 0; n < RandomItems; n++) begin
      calm = (n >= 200 && n < 300);
      if (n == 350) drain();
      random_item();
    end
    calm = 1'b0;
    drain();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
